// File: rtl/xon_xoff_serial_buffer_unit_defines.svh
// Assertion macros for the serial buffer unit.
// Depends on nothing; taken in by files that check their own logic.
`ifndef XON_XOFF_SERIAL_BUFFER_UNIT_DEFINES_SVH
`define XON_XOFF_SERIAL_BUFFER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define XXSB_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("xxsb assertion failed");
`define XXSB_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("xxsb assertion failed");
`else
`define XXSB_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define XXSB_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// File: rtl/xxsb_pkg.sv
// Shared types and constants of the serial buffer unit.
// Depends on nothing; used by the control module and the top level.
`default_nettype none
package xxsb_pkg;

  localparam int RX_DEPTH_DEF = 1024;
  localparam int TX_DEPTH_DEF = 8;
  localparam int MARK_W       = 11;
  localparam int BYTE_W       = 8;

  localparam logic [MARK_W-1:0] HIGH_MARK_RST = 11'd400;
  localparam logic [MARK_W-1:0] LOW_MARK_RST  = 11'd50;

  localparam logic [BYTE_W-1:0] XON_BYTE  = 8'h11;
  localparam logic [BYTE_W-1:0] XOFF_BYTE = 8'h13;

  localparam logic REG_HIGH_MARK = 1'b0;
  localparam logic REG_LOW_MARK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_RX       = 2'd0,
    KIND_READ     = 2'd1,
    KIND_SEND     = 2'd2,
    KIND_TX_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    logic              host_valid;
    logic              line_valid;
    logic              line_from_ram;
    logic [BYTE_W-1:0] line_byte;
    logic              rx_dropped;
    logic              tx_clogged;
    logic              flow_stopped;
  } step_t;

endpackage
`default_nettype wire

// File: rtl/xon_xoff_serial_buffer_unit.sv
// Serial link buffer with XON/XOFF flow control: one input word per event,
// one result word per event. The unit takes a new word every cycle unless
// back-pressure holds it. Each result word passes the read stage and then the
// output register: the accepting edge starts the registered RAM read of the
// receive or transmit ring and loads the read stage, and the output register
// takes the word when the result side moves on. Back-pressure on the result
// side holds the input side once two words are in flight, one in the read
// stage and one in the output register. The rings need no clearing pass after reset.
// Depends on xxsb_pkg, xxsb_ctrl, xxsb_ram and the defines header.
`default_nettype none
`include "xon_xoff_serial_buffer_unit_defines.svh"
module xon_xoff_serial_buffer_unit #(
  parameter int RX_DEPTH = xxsb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = xxsb_pkg::TX_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // data_byte
  input  wire logic [1:0]                  s_tuser,  // kind
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // host_byte, host_valid, line_byte, line_valid, rx_dropped,
  // tx_clogged, flow_stopped, zero fill
  output logic [23:0]                      m_tdata,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [xxsb_pkg::MARK_W-1:0] cfg_data
);

  logic                               accept;
  logic                               s1_valid;
  logic                               s1_adv;
  xxsb_pkg::step_t                    step;
  xxsb_pkg::step_t                    s1_step;
  logic                               rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
  logic [$clog2(RX_DEPTH)-1:0]        rx_wr_addr, rx_rd_addr;
  logic [$clog2(TX_DEPTH)-1:0]        tx_wr_addr, tx_rd_addr;
  logic [xxsb_pkg::BYTE_W-1:0]        rx_wr_data, tx_wr_data, rx_rd_data, tx_rd_data;
  logic [xxsb_pkg::BYTE_W-1:0]        host_byte, line_byte;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  xxsb_ctrl #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (xxsb_pkg::kind_t'(s_tuser)),
    .data_byte  (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_wr_en   (rx_wr_en),
    .rx_wr_addr (rx_wr_addr),
    .rx_wr_data (rx_wr_data),
    .rx_rd_en   (rx_rd_en),
    .rx_rd_addr (rx_rd_addr),
    .tx_wr_en   (tx_wr_en),
    .tx_wr_addr (tx_wr_addr),
    .tx_wr_data (tx_wr_data),
    .tx_rd_en   (tx_rd_en),
    .tx_rd_addr (tx_rd_addr),
    .step       (step)
  );

  xxsb_ram #(
    .WIDTH(xxsb_pkg::BYTE_W),
    .DEPTH(RX_DEPTH)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_wr_en),
    .wr_addr (rx_wr_addr),
    .wr_data (rx_wr_data),
    .rd_en   (rx_rd_en),
    .rd_addr (rx_rd_addr),
    .rd_data (rx_rd_data)
  );

  xxsb_ram #(
    .WIDTH(xxsb_pkg::BYTE_W),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_wr_en),
    .wr_addr (tx_wr_addr),
    .wr_data (tx_wr_data),
    .rd_en   (tx_rd_en),
    .rd_addr (tx_rd_addr),
    .rd_data (tx_rd_data)
  );

  assign host_byte = s1_step.host_valid ? rx_rd_data : '0;
  assign line_byte = !s1_step.line_valid   ? '0
                   : s1_step.line_from_ram ? tx_rd_data : s1_step.line_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step <= step;
    end
    if (s1_adv && s1_valid) begin
      m_tdata <= {3'b000, s1_step.flow_stopped, s1_step.tx_clogged, s1_step.rx_dropped,
                  s1_step.line_valid, line_byte, s1_step.host_valid, host_byte};
    end
  end

  `XXSB_ASSERT_IMPLIES(a_stall_holds_input, clk, rst, s1_valid && !s1_adv, !s_tready)
  `XXSB_ASSERT_IMPLIES(a_rx_result_excl, clk, rst, m_tvalid, !(m_tdata[8] && m_tdata[18]))
  `XXSB_ASSERT_IMPLIES(a_line_result_excl, clk, rst, m_tvalid, !(m_tdata[17] && m_tdata[19]))
  `XXSB_ASSERT_NEXT(a_accept_fills_stage, clk, rst, accept, s1_valid)

endmodule
`default_nettype wire

// File: rtl/xxsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module xxsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/xxsb_ctrl.sv
// Ring pointers, fill counts, flow-control state and mark registers.
// Depends on xxsb_pkg; drives the ports of both ring RAMs.
`default_nettype none
module xxsb_ctrl #(
  parameter int RX_DEPTH = xxsb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = xxsb_pkg::TX_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire xxsb_pkg::kind_t                  kind,
  input  wire logic [xxsb_pkg::BYTE_W-1:0]      data_byte,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [xxsb_pkg::MARK_W-1:0]      cfg_data,
  output logic                                  rx_wr_en,
  output logic [$clog2(RX_DEPTH)-1:0]           rx_wr_addr,
  output logic [xxsb_pkg::BYTE_W-1:0]           rx_wr_data,
  output logic                                  rx_rd_en,
  output logic [$clog2(RX_DEPTH)-1:0]           rx_rd_addr,
  output logic                                  tx_wr_en,
  output logic [$clog2(TX_DEPTH)-1:0]           tx_wr_addr,
  output logic [xxsb_pkg::BYTE_W-1:0]           tx_wr_data,
  output logic                                  tx_rd_en,
  output logic [$clog2(TX_DEPTH)-1:0]           tx_rd_addr,
  output xxsb_pkg::step_t                       step
);

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_FW = $clog2(RX_DEPTH + 1);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_FW = $clog2(TX_DEPTH + 1);
  localparam int CMP_W = (RX_FW > xxsb_pkg::MARK_W) ? RX_FW : xxsb_pkg::MARK_W;

  logic [xxsb_pkg::MARK_W-1:0] high_mark;
  logic [xxsb_pkg::MARK_W-1:0] low_mark;
  logic [RX_AW-1:0] rx_head, rx_head_next;
  logic [RX_AW-1:0] rx_tail, rx_tail_next;
  logic [RX_FW-1:0] rx_fill, rx_fill_next;
  logic [TX_AW-1:0] tx_head, tx_head_next;
  logic [TX_AW-1:0] tx_tail, tx_tail_next;
  logic [TX_FW-1:0] tx_fill, tx_fill_next;
  logic             xoff_sent, xoff_sent_next;
  logic             line_busy, line_busy_next;

  logic                        send_req;
  logic [xxsb_pkg::BYTE_W-1:0] send_b;
  logic [TX_FW-1:0]            tx_room;

  assign rx_wr_addr = rx_tail;
  assign rx_wr_data = data_byte;
  assign rx_rd_addr = rx_head;
  assign tx_wr_addr = tx_tail;
  assign tx_wr_data = send_b;
  assign tx_rd_addr = tx_head;

  always_comb begin
    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    rx_fill_next   = rx_fill;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    tx_fill_next   = tx_fill;
    xoff_sent_next = xoff_sent;
    line_busy_next = line_busy;
    rx_wr_en       = 1'b0;
    rx_rd_en       = 1'b0;
    tx_wr_en       = 1'b0;
    tx_rd_en       = 1'b0;
    send_req       = 1'b0;
    send_b         = data_byte;
    step           = '0;
    case (kind)
      xxsb_pkg::KIND_RX: begin
        if (rx_fill < RX_FW'(RX_DEPTH)) begin
          rx_wr_en     = accept;
          rx_tail_next = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
          rx_fill_next = rx_fill + 1'b1;
          if (CMP_W'(rx_fill_next) >= CMP_W'(high_mark) && !xoff_sent) begin
            xoff_sent_next = 1'b1;
            send_req       = 1'b1;
            send_b         = xxsb_pkg::XOFF_BYTE;
          end
        end else begin
          step.rx_dropped = 1'b1;
        end
      end
      xxsb_pkg::KIND_READ: begin
        if (rx_fill != '0) begin
          rx_rd_en        = accept;
          step.host_valid = 1'b1;
          rx_head_next    = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
          rx_fill_next    = rx_fill - 1'b1;
        end
        if (CMP_W'(rx_fill_next) < CMP_W'(low_mark) && xoff_sent) begin
          xoff_sent_next = 1'b0;
          send_req       = 1'b1;
          send_b         = xxsb_pkg::XON_BYTE;
        end
      end
      xxsb_pkg::KIND_SEND: begin
        send_req = 1'b1;
      end
      xxsb_pkg::KIND_TX_EMPTY: begin
        if (tx_fill != '0) begin
          tx_rd_en           = accept;
          step.line_valid    = 1'b1;
          step.line_from_ram = 1'b1;
          tx_head_next       = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
          tx_fill_next       = tx_fill - 1'b1;
          line_busy_next     = 1'b1;
        end else begin
          line_busy_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    tx_room = (send_b == xxsb_pkg::XON_BYTE || send_b == xxsb_pkg::XOFF_BYTE)
            ? TX_FW'(TX_DEPTH) : TX_FW'(TX_DEPTH - 1);
    if (send_req) begin
      if (!line_busy) begin
        step.line_valid = 1'b1;
        step.line_byte  = send_b;
        line_busy_next  = 1'b1;
      end else if (tx_fill < tx_room) begin
        tx_wr_en     = accept;
        tx_tail_next = (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;
        tx_fill_next = tx_fill + 1'b1;
      end else begin
        step.tx_clogged = 1'b1;
      end
    end
    step.flow_stopped = xoff_sent_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_mark <= xxsb_pkg::HIGH_MARK_RST;
      low_mark  <= xxsb_pkg::LOW_MARK_RST;
      rx_head   <= '0;
      rx_tail   <= '0;
      rx_fill   <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      tx_fill   <= '0;
      xoff_sent <= 1'b0;
      line_busy <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == xxsb_pkg::REG_HIGH_MARK) begin
          high_mark <= cfg_data;
        end else begin
          low_mark <= cfg_data;
        end
      end
      if (accept) begin
        rx_head   <= rx_head_next;
        rx_tail   <= rx_tail_next;
        rx_fill   <= rx_fill_next;
        tx_head   <= tx_head_next;
        tx_tail   <= tx_tail_next;
        tx_fill   <= tx_fill_next;
        xoff_sent <= xoff_sent_next;
        line_busy <= line_busy_next;
      end
    end
  end

endmodule
`default_nettype wire
